[rtl/assert_macros.svh]
// Assertion macros shared by the code builder RTL.
// No dependencies; the checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CHB_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define CHB_ASSERT(lbl, clk, rstn, prop)
`define CHB_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/chb_pkg.sv]
// Shared constants and types of the canonical Huffman code builder.
// No dependencies.
package chb_pkg;
    localparam int MAX_CODE_BITS = 16;
    localparam int SYMBOL_COUNT  = 256;

    localparam int KIND_W    = 2;
    localparam int LIDX_W    = 5;
    localparam int CNT_W     = 8;
    localparam int SYM_W     = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int NEXT_W    = 17;
    localparam int SYM_IDX_W = $clog2(SYMBOL_COUNT);
    localparam int LEN_IDX_W = $clog2(MAX_CODE_BITS);

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_APPEND = 2'd2,
        KIND_LOOKUP = 2'd3
    } t_kind;

    typedef struct packed {
        logic start;
        logic load;
        logic append;
    } t_alloc_cmd;

    typedef struct packed {
        logic              status;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } t_alloc_res;

    typedef struct packed {
        logic                 en;
        logic [SYM_IDX_W-1:0] addr;
        logic [CODE_W-1:0]    code;
        logic [LEN_W-1:0]     length;
    } t_store_wr;
endpackage

[rtl/chb_store.sv]
// Per-symbol code and length memory with one valid bit per entry.
// Depends on chb_pkg.
module chb_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_rd_en,
    input  logic [chb_pkg::SYM_IDX_W-1:0] i_rd_addr,
    input  chb_pkg::t_store_wr            i_wr,
    output logic [chb_pkg::CODE_W-1:0]    o_rd_code,
    output logic [chb_pkg::LEN_W-1:0]     o_rd_length,
    output logic                          o_rd_hit
);
    import chb_pkg::*;

    logic [CODE_W+LEN_W-1:0] r_mem [SYMBOL_COUNT];
    logic [CODE_W+LEN_W-1:0] r_rd_data;
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.code, i_wr.length};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_code   = r_rd_data[CODE_W+LEN_W-1:LEN_W];
    assign o_rd_length = r_rd_data[LEN_W-1:0];
    assign o_rd_hit    = r_rd_hit;
endmodule

[rtl/chb_alloc.sv]
// Canonical code allocator: length counts, running code and length state.
// Depends on chb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module chb_alloc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  chb_pkg::t_alloc_cmd        i_cmd,
    input  logic [chb_pkg::LIDX_W-1:0] i_length_index,
    input  logic [chb_pkg::CNT_W-1:0]  i_code_count,
    output chb_pkg::t_alloc_res        o_res
);
    import chb_pkg::*;

    logic [CNT_W-1:0]     r_counts [MAX_CODE_BITS];
    logic [LEN_W-1:0]     r_cur;
    logic [NEXT_W-1:0]    r_next;
    logic [CNT_W-1:0]     r_left;

    logic                 found;
    logic [LEN_IDX_W-1:0] pick;
    logic [LEN_W-1:0]     len_new;
    logic [LEN_W-1:0]     step;
    logic                 enter;
    logic                 no_code;
    logic [LEN_W-1:0]     eff_cur;
    logic [NEXT_W-1:0]    eff_next;
    logic [CNT_W-1:0]     eff_left;
    logic [LIDX_W-1:0]    lidx_m1;
    logic                 lidx_ok;

    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = MAX_CODE_BITS - 1; i >= 0; i--) begin
            if (r_counts[i] != '0 && LEN_W'(i) >= r_cur) begin
                found = 1'b1;
                pick  = LEN_IDX_W'(i);
            end
        end
    end

    assign len_new  = LEN_W'(pick) + LEN_W'(1);
    assign step     = len_new - r_cur;
    assign enter    = (r_left == '0);
    assign no_code  = enter && !found;
    assign eff_cur  = enter ? len_new : r_cur;
    assign eff_next = enter ? (r_next << step) : r_next;
    assign eff_left = enter ? r_counts[pick] : r_left;

    assign lidx_m1 = i_length_index - LIDX_W'(1);
    assign lidx_ok = (i_length_index != '0) && (i_length_index <= LIDX_W'(MAX_CODE_BITS));

    always_comb begin
        o_res.status = no_code;
        o_res.code   = no_code ? '0 : eff_next[CODE_W-1:0];
        o_res.length = no_code ? '0 : eff_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            for (int i = 0; i < MAX_CODE_BITS; i++) begin
                r_counts[i] <= '0;
            end
            r_cur  <= '0;
            r_next <= '0;
            r_left <= '0;
        end else begin
            if (i_cmd.load && lidx_ok) begin
                r_counts[lidx_m1[LEN_IDX_W-1:0]] <= i_code_count;
            end
            if (i_cmd.append && !no_code) begin
                r_cur  <= eff_cur;
                r_next <= eff_next + NEXT_W'(1);
                r_left <= eff_left - CNT_W'(1);
            end
        end
    end

    `CHB_ASSERT(a_no_length_no_left, i_clk, i_rst_n, (r_cur == '0) |-> (r_left == '0))
    `CHB_ASSERT(a_cur_in_range, i_clk, i_rst_n, r_cur <= LEN_W'(MAX_CODE_BITS))
    `CHB_ASSERT(a_append_has_length, i_clk, i_rst_n, (i_cmd.append && !o_res.status) |-> (o_res.length != '0))
endmodule

[rtl/canonical_huffman_code_builder.sv]
// Canonical Huffman code builder (JPEG Annex C table generation), top level.
// Depends on chb_pkg, chb_alloc, chb_store and assert_macros.svh.
//
// Usage: drive i_kind, i_length_index, i_code_count and i_symbol and raise
// start; the beat is taken at a rising edge with start high and busy low.
// Kinds: start a new table, load the code count of one length, append the
// next symbol in code order, look up a stored symbol.
// Every beat gives exactly one result: o_status, o_code and o_code_len
// show for one cycle with o_strobe high; o_strobe is registered from the
// ST_EXEC state entered at the accepting edge. busy is high in ST_EXEC,
// the state after acceptance, in which the symbol memory read returns and the
// allocator updates, so no new beat is taken while busy;
// a new beat may be taken at the edge that takes its predecessor's result.
// The receiver cannot stall; results are never held back.
// Reset (i_rst_n low at a clock edge) clears the length counts, the code
// state and every symbol valid bit at once; no clearing pass is needed, and
// the start kind clears the same state.
`include "assert_macros.svh"
module canonical_huffman_code_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [chb_pkg::KIND_W-1:0] i_kind,
    input  logic [chb_pkg::LIDX_W-1:0] i_length_index,
    input  logic [chb_pkg::CNT_W-1:0]  i_code_count,
    input  logic [chb_pkg::SYM_W-1:0]  i_symbol,
    output logic                       o_strobe,
    output logic                       o_status,
    output logic [chb_pkg::CODE_W-1:0] o_code,
    output logic [chb_pkg::LEN_W-1:0]  o_code_len
);
    import chb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [LIDX_W-1:0] r_lidx;
    logic [CNT_W-1:0]  r_cnt;
    logic [SYM_W-1:0]  r_sym;
    logic              r_sym_ok;
    logic              r_strobe;
    logic              r_status;
    logic [CODE_W-1:0] r_code;
    logic [LEN_W-1:0]  r_len;

    logic              accept;
    logic              exec;
    t_alloc_cmd        cmd;
    t_alloc_res        res;
    t_store_wr         wr;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;
    logic              rd_hit;
    logic              lookup_hit;

    assign accept = start && (r_state == ST_IDLE);
    assign exec   = (r_state == ST_EXEC);

    always_comb begin
        cmd.start  = exec && (r_kind == KIND_START);
        cmd.load   = exec && (r_kind == KIND_LOAD);
        cmd.append = exec && (r_kind == KIND_APPEND);
    end

    always_comb begin
        wr.en     = cmd.append && !res.status && r_sym_ok;
        wr.addr   = r_sym[SYM_IDX_W-1:0];
        wr.code   = res.code;
        wr.length = res.length;
    end

    chb_alloc u_alloc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_length_index (r_lidx),
        .i_code_count   (r_cnt),
        .o_res          (res)
    );

    chb_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cmd.start),
        .i_rd_en     (accept),
        .i_rd_addr   (i_symbol[SYM_IDX_W-1:0]),
        .i_wr        (wr),
        .o_rd_code   (rd_code),
        .o_rd_length (rd_len),
        .o_rd_hit    (rd_hit)
    );

    assign lookup_hit = rd_hit && r_sym_ok;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= t_kind'(i_kind);
            r_lidx   <= i_length_index;
            r_cnt    <= i_code_count;
            r_sym    <= i_symbol;
            r_sym_ok <= {1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_status <= 1'b0;
            r_code   <= '0;
            r_len    <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state  <= ST_IDLE;
                    r_strobe <= 1'b1;
                    unique case (r_kind)
                        KIND_APPEND: begin
                            r_status <= res.status;
                            r_code   <= res.code;
                            r_len    <= res.length;
                        end
                        KIND_LOOKUP: begin
                            r_status <= 1'b0;
                            r_code   <= lookup_hit ? rd_code : '0;
                            r_len    <= lookup_hit ? rd_len : '0;
                        end
                        default: begin
                            r_status <= 1'b0;
                            r_code   <= '0;
                            r_len    <= '0;
                        end
                    endcase
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = exec;
    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_code     = r_code;
    assign o_code_len = r_len;

    `CHB_ASSERT(a_accept_then_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `CHB_ASSERT(a_strobe_after_exec, i_clk, i_rst_n, o_strobe |-> $past(r_state == ST_EXEC))
    `CHB_ASSERT(a_status_only_append, i_clk, i_rst_n, (o_strobe && o_status) |-> $past(r_kind == KIND_APPEND))
endmodule
